### hw/rtl/linear_queue_with_search_assert.svh
// assertion macros shared by the linear queue with search rtl
`ifndef LINEAR_QUEUE_WITH_SEARCH_ASSERT_SVH
`define LINEAR_QUEUE_WITH_SEARCH_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LQS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define LQS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/lqs_pkg.sv
// shared types and constants for the linear queue with search
package lqs_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned OUT_CNT_W = 4;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		op_t                       op;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	// one command beat from the front end to the back end
	typedef struct packed {
		logic vld;
		cmd_t cmd;
	} cmd_beat_t;

endpackage

### hw/rtl/linear_queue_with_search.sv
// top level of the linear array queue with key search
//
//   port group   direction  handshake            payload
//   input beat   in         push / full          operation, value
//   result beat  out        empty / pop          status, found, occurrences, entry_count
//
// insert, delete and unused codes go from idle straight to emit in the back end; a
// query on a non-empty queue passes through scan and finish first, with one read per
// cycle of the entry store ram from head to tail during the scan.
// arst_n clears pointers, sequencer and both queues; entry store contents stay
// undefined until written. a two-slot command queue takes input beats while the
// back end works, and one result register holds a beat until it is popped.
module linear_queue_with_search #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          operation,
	input  logic signed [lqs_pkg::VALUE_W-1:0]  value,
	output logic                                empty,
	input  logic                                pop,
	output logic [1:0]                          status,
	output logic                                found,
	output logic [lqs_pkg::OUT_CNT_W-1:0]       occurrences,
	output logic [lqs_pkg::OUT_CNT_W-1:0]       entry_count
);

	import lqs_pkg::*;

	cmd_beat_t cmd_beat;
	logic      cmd_rdy;

	// accept and decode
	lqs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.value     (value),
		.cmd_out   (cmd_beat),
		.cmd_rdy   (cmd_rdy)
	);

	// execute and report
	lqs_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_in      (cmd_beat),
		.cmd_rdy     (cmd_rdy),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.found       (found),
		.occurrences (occurrences),
		.entry_count (entry_count)
	);

endmodule

### hw/rtl/lqs_ram.sv
// generic single-write, single-read ram with registered read data
module lqs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hw/rtl/lqs_front.sv
// front end: accepts input beats, decodes them and buffers two commands
module lqs_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [1:0]                          operation,
	input  logic signed [lqs_pkg::VALUE_W-1:0]  value,
	output lqs_pkg::cmd_beat_t                  cmd_out,
	input  logic                                cmd_rdy
);

	import lqs_pkg::*;
	`include "linear_queue_with_search_assert.svh"

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push_acc;
	logic       pop_acc;
	cmd_t       dec_cmd;

	// decode the incoming beat into a command
	always_comb begin
		dec_cmd.op    = op_t'(operation);
		dec_cmd.value = value;
	end

	assign full     = (cnt_q == 2'd2);
	assign push_acc = push && !full;
	assign pop_acc  = cmd_rdy && (cnt_q != 2'd0);

	assign cmd_out.vld = (cnt_q != 2'd0);
	assign cmd_out.cmd = slot_q[rd_ptr_q];

	// two-slot command queue, control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_acc) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_acc) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push_acc && !pop_acc) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop_acc && !push_acc) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// two-slot command queue, payload
	always_ff @(posedge clk) begin
		if (push_acc) begin
			slot_q[wr_ptr_q] <= dec_cmd;
		end
	end

	`LQS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= 2'd2, "command queue count out of range")
	`LQS_ASSERT_NXT(a_cnt_grow, push_acc && !pop_acc, cnt_q == $past(cnt_q) + 2'd1,
		"command queue count did not grow on push")

endmodule

### hw/rtl/lqs_back.sv
// back end: executes insert, delete and query against the entry store
module lqs_back #(
	parameter int unsigned DEPTH = 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lqs_pkg::cmd_beat_t                  cmd_in,
	output logic                                cmd_rdy,
	output logic                                empty,
	input  logic                                pop,
	output logic [1:0]                          status,
	output logic                                found,
	output logic [lqs_pkg::OUT_CNT_W-1:0]       occurrences,
	output logic [lqs_pkg::OUT_CNT_W-1:0]       entry_count
);

	import lqs_pkg::*;
	`include "linear_queue_with_search_assert.svh"

	localparam int unsigned IW = $clog2(DEPTH);
	localparam int unsigned CW = ($clog2(DEPTH + 1) > OUT_CNT_W) ?
		$clog2(DEPTH + 1) : OUT_CNT_W;
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_EMIT
	} state_t;

	state_t                    state_q;
	logic [IW-1:0]             head_q;
	logic [IW-1:0]             tail_q;
	logic                      empty_q;
	logic [IW-1:0]             ptr_q;
	logic signed [VALUE_W-1:0] key_q;
	logic [CW-1:0]             occ_q;
	logic                      rd_vld_s1;
	status_t                   res_status_q;
	logic                      out_vld_q;
	status_t                   out_status_q;
	logic                      out_found_q;
	logic [OUT_CNT_W-1:0]      out_occ_q;
	logic [OUT_CNT_W-1:0]      out_cnt_q;

	logic                      ram_we;
	logic [IW-1:0]             ram_waddr;
	logic [VALUE_W-1:0]        ram_rdata;
	logic [CW-1:0]             live_cnt;
	logic                      hit;
	logic                      out_free;

	assign cmd_rdy = (state_q == S_IDLE);

	// entry store writes on a successful insert
	assign ram_we    = (state_q == S_IDLE) && cmd_in.vld && (cmd_in.cmd.op == OP_INSERT) &&
		(empty_q || (tail_q != LAST));
	assign ram_waddr = empty_q ? '0 : tail_q + 1'b1;

	lqs_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (cmd_in.cmd.value),
		.raddr (ptr_q),
		.rdata (ram_rdata)
	);

	// live entries and compare of the entry read last cycle
	assign live_cnt = empty_q ? '0 : CW'(tail_q - head_q) + 1'b1;
	assign hit      = rd_vld_s1 && (signed'(ram_rdata) == key_q);
	assign out_free = !out_vld_q || pop;

	// sequencer, queue pointers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			empty_q      <= 1'b1;
			ptr_q        <= '0;
			key_q        <= '0;
			occ_q        <= '0;
			rd_vld_s1    <= 1'b0;
			res_status_q <= STAT_DONE;
			out_vld_q    <= 1'b0;
			out_status_q <= STAT_DONE;
			out_found_q  <= 1'b0;
			out_occ_q    <= '0;
			out_cnt_q    <= '0;
		end else begin
			rd_vld_s1 <= (state_q == S_SCAN);
			if (hit) begin
				occ_q <= occ_q + 1'b1;
			end
			if (pop && (state_q != S_EMIT)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_in.vld) begin
						res_status_q <= STAT_DONE;
						occ_q        <= '0;
						state_q      <= S_EMIT;
						case (cmd_in.cmd.op)
							OP_INSERT: begin
								if (empty_q) begin
									head_q  <= '0;
									tail_q  <= '0;
									empty_q <= 1'b0;
								end else if (tail_q == LAST) begin
									res_status_q <= STAT_FULL;
								end else begin
									tail_q <= tail_q + 1'b1;
								end
							end
							OP_DELETE: begin
								if (empty_q) begin
									res_status_q <= STAT_EMPTY;
								end else if (head_q == tail_q) begin
									head_q  <= '0;
									tail_q  <= '0;
									empty_q <= 1'b1;
								end else begin
									head_q <= head_q + 1'b1;
								end
							end
							OP_QUERY: begin
								if (empty_q) begin
									res_status_q <= STAT_EMPTY;
								end else begin
									key_q   <= cmd_in.cmd.value;
									ptr_q   <= head_q;
									state_q <= S_SCAN;
								end
							end
							default: begin
								res_status_q <= STAT_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					// one read per cycle from head to tail
					if (ptr_q == tail_q) begin
						state_q <= S_FINISH;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				S_FINISH: begin
					// last compare lands this cycle
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_vld_q    <= 1'b1;
						out_status_q <= res_status_q;
						out_found_q  <= (occ_q != '0);
						out_occ_q    <= occ_q[OUT_CNT_W-1:0];
						out_cnt_q    <= live_cnt[OUT_CNT_W-1:0];
						state_q      <= S_IDLE;
					end else if (pop) begin
						out_vld_q <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign empty       = !out_vld_q;
	assign status      = out_status_q;
	assign found       = out_found_q;
	assign occurrences = out_occ_q;
	assign entry_count = out_cnt_q;

	`LQS_ASSERT_IMP(a_empty_ptrs, empty_q, head_q == '0 && tail_q == '0,
		"empty queue with pointers off slot zero")
	`LQS_ASSERT_IMP(a_head_le_tail, 1'b1, head_q <= tail_q, "head ran past tail")
	`LQS_ASSERT_IMP(a_occ_bound, state_q == S_EMIT, occ_q <= live_cnt,
		"match count exceeds live entries")
	`LQS_ASSERT_NXT(a_finish_emit, state_q == S_FINISH, state_q == S_EMIT,
		"scan did not close into result")

endmodule
